[rtl/saq_pkg.sv]
package saq_pkg;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 4;
  localparam int TIME_W   = 64;
  localparam int KIND_W   = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_BASE  = 2'd0,
    ACT_SLEEP = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUEUED   = 3'd0,
    KIND_PASSED   = 3'd1,
    KIND_WOKEN    = 3'd2,
    KIND_NONE_DUE = 3'd3,
    KIND_BASE_SET = 3'd4,
    KIND_BUSY     = 3'd5
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_S_ADD,
    ST_S_CHK,
    ST_S_STEP,
    ST_S_RDWT,
    ST_S_CMP,
    ST_S_PLACE,
    ST_T_STEP,
    ST_T_RDWT,
    ST_T_CMP,
    ST_T_WAKE,
    ST_T_EMIT,
    ST_E_BUSY,
    ST_E_BASE,
    ST_E_PASS,
    ST_E_QUEUED,
    ST_E_NONE
  } state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic  cap;
    logic  wt_rd;
    logic  wt_addr_ord;
    logic  wt_wr_now;
    logic  wt_wr_sum;
    logic  ord_rd;
    logic  ord_prev;
    logic  ord_wr_shift;
    logic  ord_wr_slot;
    logic  j_clr;
    logic  j_cnt;
    logic  j_inc;
    logic  j_dec;
    logic  due_lat;
    logic  cmp_from_w;
    logic  cmp_from_wt;
    logic  irq_set;
    logic  irq_clr;
    logic  ins_commit;
    logic  tick_commit;
    logic  unq;
    logic  emit;
    kind_e kind;
    logic  last;
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    action_e action;
    logic    slot_ok;
    logic    passed;
    logic    wt_ge_w;
    logic    wt_le_now;
    logic    j_zero;
    logic    j_lt_count;
    logic    j_at_due;
    logic    j_last;
    logic    due_zero;
    logic    out_free;
  } sts_t;

endpackage

[rtl/saq_in_if.sv]
interface saq_in_if import saq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     alarm_id;
  logic [TIME_W-1:0]   sleep_ticks;
  logic [TIME_W-1:0]   now;

  modport source (output valid, action, alarm_id, sleep_ticks, now, input ready);
  modport sink (input valid, action, alarm_id, sleep_ticks, now, output ready);
endinterface

[rtl/saq_out_if.sv]
interface saq_out_if import saq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   woken_id;
  logic [TIME_W-1:0] compare_value;
  logic              compare_enable;
  logic              last;

  modport source (output valid, kind, woken_id, compare_value, compare_enable, last,
                  input ready);
  modport sink (input valid, kind, woken_id, compare_value, compare_enable, last,
                output ready);
endinterface

[rtl/sorted_alarm_queue_top.sv]
// A sleep that has not passed walks the queue back from the tail, moving each entry at or
// after the new wake time up by one, and stops early at an earlier entry; a tick counts the
// due entries from the head, then reports each due entry as woken.
// Items are handled one at a time: a new input is taken only in idle, after the last is done.
// Reset: asynchronous, active low; the queue empties, wake times read as zero, the compare
module sorted_alarm_queue_top import saq_pkg::*; #(
  parameter int NUM_ALARMS = 16,
  parameter int TIME_BITS  = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  saq_in_if.sink    in_i,
  saq_out_if.source out_o
);

  // value is all ones and the interrupt enable is off; no clearing pass is needed.
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  saq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  saq_datapath #(
    .NUM_ALARMS (NUM_ALARMS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (in_i.action),
    .alarm_id_i       (in_i.alarm_id),
    .sleep_ticks_i    (in_i.sleep_ticks),
    .now_i            (in_i.now),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .kind_o           (out_o.kind),
    .woken_id_o       (out_o.woken_id),
    .compare_value_o  (out_o.compare_value),
    .compare_enable_o (out_o.compare_enable),
    .last_o           (out_o.last)
  );

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded while output register still held");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again right after a transfer");

  a_wt_wr_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wt_wr_now && cmd.wt_wr_sum))
    else $error("two wake time write sources at once");

  a_ord_wr_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ord_wr_shift && cmd.ord_wr_slot))
    else $error("two order list write sources at once");
`endif

endmodule

[rtl/saq_datapath.sv]
module saq_datapath import saq_pkg::*; #(
  parameter int NUM_ALARMS = 16,
  parameter int TIME_BITS  = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [ID_W-1:0]     alarm_id_i,
  input  logic [TIME_W-1:0]   sleep_ticks_i,
  input  logic [TIME_W-1:0]   now_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [KIND_W-1:0]   kind_o,
  output logic [ID_W-1:0]     woken_id_o,
  output logic [TIME_W-1:0]   compare_value_o,
  output logic                compare_enable_o,
  output logic                last_o
);

  localparam int IW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int CW = IW + 1;
  localparam int XW = (CW > ID_W) ? CW : ID_W;
  localparam logic [CW-1:0] NUM_C = CW'(NUM_ALARMS);

  // captured item
  action_e             act_q;
  logic [ID_W-1:0]     id_q;
  logic [IW-1:0]       slot_q;
  logic [TIME_BITS-1:0] ticks_q;
  logic [TIME_BITS-1:0] now_q;

  // storage
  logic [TIME_BITS-1:0] wt_mem [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] wt_valid_q;
  logic [IW-1:0]        ord_mem [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] queued_q;
  logic [CW-1:0]        count_q;
  logic [IW-1:0]        head_q;
  logic [TIME_BITS-1:0] cmp_q;
  logic                 irq_q;

  // walk registers
  logic [CW-1:0]        j_q;
  logic [CW-1:0]        due_q;
  logic [TIME_BITS-1:0] w_q;
  logic [TIME_BITS-1:0] wt_rdata_q;
  logic                 wt_rvalid_q;
  logic [IW-1:0]        ord_q;

  // output register
  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [ID_W-1:0]      out_id_q;
  logic [TIME_BITS-1:0] out_cmp_q;
  logic                 out_en_q;
  logic                 out_last_q;

  logic [TIME_BITS-1:0] wt_rd_val;
  logic [IW-1:0]        wt_addr;
  logic [TIME_BITS-1:0] wt_wdata;
  logic                 wt_wr_en;
  logic [TIME_BITS:0]   sum_full;
  logic [TIME_BITS-1:0] w_next;
  logic [IW-1:0]        ord_raddr;
  logic [IW-1:0]        ord_waddr;
  logic [IW-1:0]        ord_wdata;
  logic [CW-1:0]        j_prev;
  logic                 id_in_range;
  logic [ID_W-1:0]      emit_id;

  // list position to physical entry in the circular order list
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [CW-1:0] s;
    s = CW'(head) + pos;
    if (s >= NUM_C) begin
      s = s - NUM_C;
    end
    return s[IW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      act_q   <= action_e'(action_i);
      id_q    <= alarm_id_i;
      slot_q  <= IW'(alarm_id_i);
      ticks_q <= TIME_BITS'(sleep_ticks_i);
      now_q   <= TIME_BITS'(now_i);
    end
  end

  assign wt_rd_val = wt_rvalid_q ? wt_rdata_q : '0;
  assign sum_full  = {1'b0, wt_rd_val} + {1'b0, ticks_q};
  assign w_next    = sum_full[TIME_BITS] ? '1 : sum_full[TIME_BITS-1:0];
  assign wt_addr   = cmd_i.wt_addr_ord ? ord_q : slot_q;
  assign wt_wr_en  = cmd_i.wt_wr_now | cmd_i.wt_wr_sum;
  assign wt_wdata  = cmd_i.wt_wr_sum ? w_next : now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wt_rd) begin
      wt_rdata_q  <= wt_mem[wt_addr];
      wt_rvalid_q <= wt_valid_q[wt_addr];
    end
    if (wt_wr_en) begin
      wt_mem[wt_addr] <= wt_wdata;
    end
  end

  assign j_prev    = j_q - CW'(1);
  assign ord_raddr = phys(head_q, cmd_i.ord_prev ? j_prev : j_q);
  assign ord_waddr = phys(head_q, j_q);
  assign ord_wdata = cmd_i.ord_wr_shift ? ord_q : slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ord_rd) begin
      ord_q <= ord_mem[ord_raddr];
    end
    if (cmd_i.ord_wr_shift || cmd_i.ord_wr_slot) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wt_wr_sum) begin
      w_q <= w_next;
    end
    if (cmd_i.j_clr) begin
      j_q <= '0;
    end else if (cmd_i.j_cnt) begin
      j_q <= count_q;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + CW'(1);
    end else if (cmd_i.j_dec) begin
      j_q <= j_prev;
    end
    if (cmd_i.due_lat) begin
      due_q <= j_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_valid_q <= '0;
      queued_q   <= '0;
      count_q    <= '0;
      head_q     <= '0;
      cmp_q      <= '1;
      irq_q      <= 1'b0;
    end else begin
      if (wt_wr_en) begin
        wt_valid_q[wt_addr] <= 1'b1;
      end
      if (cmd_i.ins_commit) begin
        queued_q[slot_q] <= 1'b1;
        count_q          <= count_q + CW'(1);
      end
      if (cmd_i.unq) begin
        queued_q[ord_q] <= 1'b0;
      end
      if (cmd_i.tick_commit) begin
        head_q  <= phys(head_q, due_q);
        count_q <= count_q - due_q;
      end
      if (cmd_i.cmp_from_w) begin
        cmp_q <= w_q;
      end else if (cmd_i.cmp_from_wt) begin
        cmp_q <= wt_rd_val;
      end
      if (cmd_i.irq_set) begin
        irq_q <= 1'b1;
      end else if (cmd_i.irq_clr) begin
        irq_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (cmd_i.kind == KIND_NONE_DUE) begin
      emit_id = '0;
    end else if (cmd_i.kind == KIND_WOKEN) begin
      emit_id = ID_W'(ord_q);
    end else begin
      emit_id = id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_id_q   <= emit_id;
      out_cmp_q  <= cmp_q;
      out_en_q   <= irq_q;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_kind_q;
  assign woken_id_o       = out_id_q;
  assign compare_value_o  = TIME_W'(out_cmp_q);
  assign compare_enable_o = out_en_q;
  assign last_o           = out_last_q;

  assign id_in_range = XW'(id_q) < XW'(NUM_ALARMS);

  always_comb begin
    sts_o.action     = act_q;
    sts_o.slot_ok    = id_in_range && !queued_q[slot_q];
    sts_o.passed     = w_q < now_q;
    sts_o.wt_ge_w    = wt_rd_val >= w_q;
    sts_o.wt_le_now  = wt_rd_val <= now_q;
    sts_o.j_zero     = j_q == '0;
    sts_o.j_lt_count = j_q < count_q;
    sts_o.j_at_due   = j_q == due_q;
    sts_o.j_last     = (j_q + CW'(1)) == due_q;
    sts_o.due_zero   = due_q == '0;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

[rtl/saq_ctrl.sv]
module saq_ctrl import saq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.last = 1'b1;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.action)
          ACT_BASE: begin
            if (!sts_i.slot_ok) begin
              state_d = ST_E_BUSY;
            end else begin
              cmd_o.wt_wr_now = 1'b1;
              state_d         = ST_E_BASE;
            end
          end
          ACT_SLEEP: begin
            if (!sts_i.slot_ok) begin
              state_d = ST_E_BUSY;
            end else begin
              cmd_o.wt_rd = 1'b1;
              state_d     = ST_S_ADD;
            end
          end
          ACT_TICK: begin
            cmd_o.j_clr = 1'b1;
            state_d     = ST_T_STEP;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_S_ADD: begin
        cmd_o.wt_wr_sum = 1'b1;
        state_d         = ST_S_CHK;
      end
      ST_S_CHK: begin
        if (sts_i.passed) begin
          state_d = ST_E_PASS;
        end else begin
          cmd_o.j_cnt = 1'b1;
          state_d     = ST_S_STEP;
        end
      end
      // walk back from the tail, moving later-or-equal entries up by one
      ST_S_STEP: begin
        if (sts_i.j_zero) begin
          state_d = ST_S_PLACE;
        end else begin
          cmd_o.ord_rd   = 1'b1;
          cmd_o.ord_prev = 1'b1;
          state_d        = ST_S_RDWT;
        end
      end
      ST_S_RDWT: begin
        cmd_o.wt_rd       = 1'b1;
        cmd_o.wt_addr_ord = 1'b1;
        state_d           = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (sts_i.wt_ge_w) begin
          cmd_o.ord_wr_shift = 1'b1;
          cmd_o.j_dec        = 1'b1;
          state_d            = ST_S_STEP;
        end else begin
          state_d = ST_S_PLACE;
        end
      end
      ST_S_PLACE: begin
        cmd_o.ord_wr_slot = 1'b1;
        cmd_o.cmp_from_w  = sts_i.j_zero;
        cmd_o.irq_set     = 1'b1;
        cmd_o.ins_commit  = 1'b1;
        state_d           = ST_E_QUEUED;
      end
      // first pass: count due entries from the head
      ST_T_STEP: begin
        if (!sts_i.j_lt_count) begin
          cmd_o.irq_clr = 1'b1;
          cmd_o.due_lat = 1'b1;
          cmd_o.j_clr   = 1'b1;
          state_d       = ST_T_WAKE;
        end else begin
          cmd_o.ord_rd = 1'b1;
          state_d      = ST_T_RDWT;
        end
      end
      ST_T_RDWT: begin
        cmd_o.wt_rd       = 1'b1;
        cmd_o.wt_addr_ord = 1'b1;
        state_d           = ST_T_CMP;
      end
      ST_T_CMP: begin
        if (sts_i.wt_le_now) begin
          cmd_o.j_inc = 1'b1;
          state_d     = ST_T_STEP;
        end else begin
          cmd_o.cmp_from_wt = 1'b1;
          cmd_o.due_lat     = 1'b1;
          cmd_o.j_clr       = 1'b1;
          state_d           = ST_T_WAKE;
        end
      end
      // second pass: wake and report each due entry, then drop them
      ST_T_WAKE: begin
        if (sts_i.due_zero) begin
          state_d = ST_E_NONE;
        end else if (sts_i.j_at_due) begin
          cmd_o.tick_commit = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.ord_rd = 1'b1;
          state_d      = ST_T_EMIT;
        end
      end
      ST_T_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.kind        = KIND_WOKEN;
          cmd_o.last        = sts_i.j_last;
          cmd_o.wt_wr_now   = 1'b1;
          cmd_o.wt_addr_ord = 1'b1;
          cmd_o.unq         = 1'b1;
          cmd_o.j_inc       = 1'b1;
          state_d           = ST_T_WAKE;
        end
      end
      ST_E_BUSY: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_BUSY;
          state_d    = ST_IDLE;
        end
      end
      ST_E_BASE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_BASE_SET;
          state_d    = ST_IDLE;
        end
      end
      ST_E_PASS: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_PASSED;
          state_d    = ST_IDLE;
        end
      end
      ST_E_QUEUED: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_QUEUED;
          state_d    = ST_IDLE;
        end
      end
      ST_E_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_NONE_DUE;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
